FILE: hdl/asp_pkg.sv
// Shared types and constants for the aligned struct packer.
`timescale 1ns / 1ps
`default_nettype none

package asp_pkg;

    localparam int MAX_FIELDS = 16;
    localparam int CNT_W      = 5;
    localparam int TYPES_W    = 32;
    localparam int NUM_TYPED  = TYPES_W / 2;
    localparam int FIDX_W     = $clog2(MAX_FIELDS + 1);
    localparam int CMP_W      = ((FIDX_W > CNT_W) ? FIDX_W : CNT_W) + 1;
    localparam int BYTE_W     = 8;
    localparam int BUF_DEPTH  = 8;
    localparam int BIDX_W     = $clog2(BUF_DEPTH);
    localparam int REC_W      = 8;
    localparam int OFF_W      = 8;
    localparam int PAD_W      = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FIELD_COUNT  = 2'd0,
        REG_FIELD_TYPES  = 2'd1,
        REG_BIG_ENDIAN   = 2'd2,
        REG_RECORD_COUNT = 2'd3
    } cfg_reg_t;

    typedef struct packed {
        logic [CNT_W-1:0]   field_count;
        logic [TYPES_W-1:0] field_types;
        logic               big_endian;
        logic [REC_W-1:0]   record_count;
    } cfg_t;

    typedef struct packed {
        logic [BUF_DEPTH-1:0][BYTE_W-1:0] bytes;
        logic [BIDX_W-1:0]                last_idx;
        logic                             rec_end;
        logic                             str_end;
    } job_t;

endpackage

`default_nettype wire

FILE: hdl/asp_cfg.sv
// Configuration register file of the aligned struct packer.
`timescale 1ns / 1ps
`default_nettype none

module asp_cfg
    import asp_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                       cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_FIELD_COUNT:  cfg_next.field_count  = cfg_data[CNT_W-1:0];
                REG_FIELD_TYPES:  cfg_next.field_types  = cfg_data[TYPES_W-1:0];
                REG_BIG_ENDIAN:   cfg_next.big_endian   = cfg_data[0];
                REG_RECORD_COUNT: cfg_next.record_count = cfg_data[REC_W-1:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.field_count  <= CNT_W'(1);
            cfg_reg.field_types  <= '0;
            cfg_reg.big_endian   <= 1'b0;
            cfg_reg.record_count <= REC_W'(1);
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

FILE: hdl/asp_ctrl.sv
// Layout tracker: padding drop, field and record boundaries, field buffer.
`timescale 1ns / 1ps
`default_nettype none

module asp_ctrl
    import asp_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire cfg_t              cfg,
    input  wire logic              accept,
    input  wire logic [BYTE_W-1:0] mem_byte,
    output logic                   job_load,
    output job_t                   job
);

    function automatic logic [1:0] code_of(input logic [TYPES_W-1:0] types,
                                           input logic [CMP_W-1:0] idx);
        logic [1:0] c;
        c = 2'd0;
        for (int i = 0; i < NUM_TYPED; i++)
        begin
            if (idx == CMP_W'(i))
            begin
                c = types[2*i +: 2];
            end
        end
        return c;
    endfunction

    function automatic logic [PAD_W-1:0] pad_for(input logic [OFF_W-1:0] off,
                                                 input logic [1:0] code);
        logic [PAD_W-1:0] mask;
        case (code)
            2'd0:    mask = 3'd0;
            2'd1:    mask = 3'd1;
            2'd2:    mask = 3'd3;
            default: mask = 3'd7;
        endcase
        return (PAD_W'(0) - off[PAD_W-1:0]) & mask;
    endfunction

    logic [FIDX_W-1:0] field_index_reg, field_index_next;
    logic [BIDX_W-1:0] byte_in_field_reg, byte_in_field_next;
    logic [PAD_W-1:0]  pad_remaining_reg, pad_remaining_next;
    logic [OFF_W-1:0]  struct_offset_reg, struct_offset_next;
    logic [REC_W-1:0]  records_done_reg, records_done_next;
    logic [BYTE_W-1:0] field_buffer_reg [BUF_DEPTH];
    logic [BYTE_W-1:0] field_buffer_next [BUF_DEPTH];

    logic [CMP_W-1:0]  fc_ext;
    logic [CMP_W-1:0]  eff_count;
    logic [CMP_W-1:0]  next_idx;
    logic              has1, has2, has3;
    logic [1:0]        max_code;
    logic [1:0]        cur_code;
    logic [3:0]        cur_size;
    logic [3:0]        bif_plus;
    logic              field_done;
    logic              rec_done;
    logic [OFF_W-1:0]  off_inc;
    logic [REC_W-1:0]  rec_target;
    logic [REC_W-1:0]  rd_inc;
    logic              str_done;
    logic [BIDX_W-1:0] merge_idx;
    logic [1:0]        c_i;

    always_comb
    begin
        fc_ext    = CMP_W'(cfg.field_count);
        if (fc_ext == '0)
        begin
            eff_count = CMP_W'(1);
        end
        else if (fc_ext > CMP_W'(MAX_FIELDS))
        begin
            eff_count = CMP_W'(MAX_FIELDS);
        end
        else
        begin
            eff_count = fc_ext;
        end

        has1 = 1'b0;
        has2 = 1'b0;
        has3 = 1'b0;
        for (int i = 0; i < NUM_TYPED; i++)
        begin
            c_i = cfg.field_types[2*i +: 2];
            if (CMP_W'(i) < eff_count)
            begin
                has1 = has1 | (c_i == 2'd1);
                has2 = has2 | (c_i == 2'd2);
                has3 = has3 | (c_i == 2'd3);
            end
        end
        max_code = has3 ? 2'd3 : (has2 ? 2'd2 : (has1 ? 2'd1 : 2'd0));

        next_idx   = CMP_W'(field_index_reg) + CMP_W'(1);
        cur_code   = code_of(cfg.field_types, CMP_W'(field_index_reg));
        cur_size   = 4'd1 << cur_code;
        bif_plus   = {1'b0, byte_in_field_reg} + 4'd1;
        field_done = (bif_plus >= cur_size);
        rec_done   = field_done && (next_idx >= eff_count);
        off_inc    = struct_offset_reg + OFF_W'(1);
        rec_target = (cfg.record_count == '0) ? REC_W'(1) : cfg.record_count;
        rd_inc     = records_done_reg + REC_W'(1);
        str_done   = rec_done && (rd_inc >= rec_target);

        merge_idx = cfg.big_endian ? byte_in_field_reg : '0;
        for (int i = 0; i < BUF_DEPTH; i++)
        begin
            job.bytes[i] = (merge_idx == BIDX_W'(i)) ? mem_byte : field_buffer_reg[i];
        end
        job.last_idx = merge_idx;
        job.rec_end  = rec_done;
        job.str_end  = str_done;

        field_index_next   = field_index_reg;
        byte_in_field_next = byte_in_field_reg;
        pad_remaining_next = pad_remaining_reg;
        struct_offset_next = struct_offset_reg;
        records_done_next  = records_done_reg;
        field_buffer_next  = field_buffer_reg;
        job_load           = 1'b0;

        if (accept)
        begin
            if (pad_remaining_reg != '0)
            begin
                pad_remaining_next = pad_remaining_reg - PAD_W'(1);
                struct_offset_next = off_inc;
            end
            else
            begin
                field_buffer_next[byte_in_field_reg] = mem_byte;
                job_load = !cfg.big_endian || field_done;
                if (field_done)
                begin
                    byte_in_field_next = '0;
                    if (rec_done)
                    begin
                        field_index_next   = '0;
                        struct_offset_next = '0;
                        pad_remaining_next = pad_for(off_inc, max_code);
                        records_done_next  = str_done ? '0 : rd_inc;
                    end
                    else
                    begin
                        field_index_next   = next_idx[FIDX_W-1:0];
                        struct_offset_next = off_inc;
                        pad_remaining_next = pad_for(off_inc,
                                                     code_of(cfg.field_types, next_idx));
                    end
                end
                else
                begin
                    byte_in_field_next = byte_in_field_reg + BIDX_W'(1);
                    struct_offset_next = off_inc;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            field_index_reg   <= '0;
            byte_in_field_reg <= '0;
            pad_remaining_reg <= '0;
            struct_offset_reg <= '0;
            records_done_reg  <= '0;
        end
        else
        begin
            field_index_reg   <= field_index_next;
            byte_in_field_reg <= byte_in_field_next;
            pad_remaining_reg <= pad_remaining_next;
            struct_offset_reg <= struct_offset_next;
            records_done_reg  <= records_done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        field_buffer_reg <= field_buffer_next;
    end

    a_pad_at_field_start: assert property (@(posedge clk) disable iff (!rst_n)
        (pad_remaining_reg != '0) |-> (byte_in_field_reg == '0))
        else $error("padding pending in the middle of a field");

    a_index_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        CMP_W'(field_index_reg) < CMP_W'(MAX_FIELDS))
        else $error("field index beyond the field limit");

    a_stream_end_resets: assert property (@(posedge clk) disable iff (!rst_n)
        (job_load && job.str_end) |=> (records_done_reg == '0) && (field_index_reg == '0))
        else $error("record counter not cleared at stream end");

endmodule

`default_nettype wire

FILE: hdl/asp_emit.sv
// Result register: holds one transaction's bytes and plays them out.
`timescale 1ns / 1ps
`default_nettype none

module asp_emit
    import asp_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         job_load,
    input  wire job_t         job,
    output logic              take,
    output logic              out_valid,
    input  wire logic         out_ready,
    output logic [BYTE_W-1:0] out_byte,
    output logic              record_end,
    output logic              stream_end,
    output logic              run_last
);

    logic              busy_reg, busy_next;
    logic [BIDX_W-1:0] idx_reg, idx_next;
    job_t              job_reg, job_next;
    logic              last;
    logic              fire;

    always_comb
    begin
        last = (idx_reg == '0);
        fire = busy_reg && out_ready;
        take = !busy_reg || (last && out_ready);

        busy_next = busy_reg;
        idx_next  = idx_reg;
        job_next  = job_reg;
        if (fire)
        begin
            if (last)
            begin
                busy_next = 1'b0;
            end
            else
            begin
                idx_next = idx_reg - BIDX_W'(1);
            end
        end
        if (job_load)
        begin
            busy_next = 1'b1;
            idx_next  = job.last_idx;
            job_next  = job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            idx_reg  <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg <= job_next;
    end

    assign out_valid  = busy_reg;
    assign out_byte   = job_reg.bytes[idx_reg];
    assign record_end = last && job_reg.rec_end;
    assign stream_end = last && job_reg.str_end;
    assign run_last   = last;

    a_countdown: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && out_ready && !last) |=> busy_reg && (idx_reg == $past(idx_reg) - BIDX_W'(1)))
        else $error("burst index did not step down");

    a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        job_load |-> take)
        else $error("new transaction loaded over a pending burst");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && !out_ready) |=> busy_reg && $stable(idx_reg))
        else $error("burst advanced while stalled");

    a_stream_marks_record: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && stream_end) |-> record_end)
        else $error("stream end without record end");

endmodule

`default_nettype wire

FILE: hdl/aligned_struct_packer.sv
// Top level of the aligned struct packer.
//
//   channel  | handshake             | payload
//   ---------+-----------------------+-------------------------------------------
//   input    | in_valid / in_ready   | mem_byte
//   output   | out_valid / out_ready | out_byte, record_end, stream_end, run_last
//   config   | cfg_we                | cfg_index, cfg_data
//
// One input byte is taken per in_ready cycle. A padding byte or a buffered
// big-endian byte yields nothing; a little-endian field byte yields one result;
// the last byte of a big-endian field yields one result per buffered byte, played
// out of the result register one per out_ready cycle, and input stalls until its
// last one. in_ready rises again in the cycle that the last pending result is
// taken. Reset clears the layout counters and the config to its defaults.
`timescale 1ns / 1ps
`default_nettype none

module aligned_struct_packer
    import asp_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire logic [BYTE_W-1:0]     mem_byte,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic [BYTE_W-1:0]          out_byte,
    output logic                       record_end,
    output logic                       stream_end,
    output logic                       run_last,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t cfg;
    job_t job;
    logic job_load;
    logic accept;

    assign accept = in_valid && in_ready;

    asp_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    asp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .accept   (accept),
        .mem_byte (mem_byte),
        .job_load (job_load),
        .job      (job)
    );

    asp_emit u_emit (
        .clk        (clk),
        .rst_n      (rst_n),
        .job_load   (job_load),
        .job        (job),
        .take       (in_ready),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_byte   (out_byte),
        .record_end (record_end),
        .stream_end (stream_end),
        .run_last   (run_last)
    );

endmodule

`default_nettype wire

FILE: test/aligned_struct_packer_tb.sv
// Testbench for aligned_struct_packer: random C struct images checked against a layout scoreboard.
`timescale 1ns / 1ps

module aligned_struct_packer_tb;
    import asp_pkg::*;

    localparam int STALL_LIMIT  = 1000;
    localparam int SETTLE       = 8;
    localparam int LONG_HOLD    = 60;
    localparam int RANDOM_ITEMS = 110;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              rec_end;
        logic              str_end;
        logic              last;
    } packed_byte_t;

    class packer_scoreboard;
        logic [CNT_W-1:0]   n_fields;
        logic [TYPES_W-1:0] types;
        logic               swap;
        logic [REC_W-1:0]   n_records;
        int unsigned        field_idx;
        int unsigned        byte_idx;
        int unsigned        pad_left;
        int unsigned        offset;
        int unsigned        records;
        logic [BYTE_W-1:0]  fbuf [BUF_DEPTH];
        packed_byte_t       packed_q [$];
        int                 errors;

        function new();
            n_fields = CNT_W'(1);
            types = '0;
            swap = 1'b0;
            n_records = REC_W'(1);
            field_idx = 0;
            byte_idx = 0;
            pad_left = 0;
            offset = 0;
            records = 0;
            errors = 0;
            foreach (fbuf[i])
                fbuf[i] = '0;
        endfunction

        function void flag(string msg);
            errors++;
            if (errors <= 10)
                $display("%s", msg);
        endfunction

        function int unsigned pending();
            return packed_q.size();
        endfunction

        function bit at_stream_start();
            return field_idx == 0 && byte_idx == 0 && pad_left == 0 && records == 0;
        endfunction

        function void write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] d);
            case (idx)
                REG_FIELD_COUNT:  n_fields = d[CNT_W-1:0];
                REG_FIELD_TYPES:  types = d[TYPES_W-1:0];
                REG_BIG_ENDIAN:   swap = d[0];
                REG_RECORD_COUNT: n_records = d[REC_W-1:0];
                default: ;
            endcase
        endfunction

        function int unsigned eff_fields();
            int unsigned c;
            c = 32'(n_fields);
            if (c == 0)
                c = 1;
            if (c > MAX_FIELDS)
                c = MAX_FIELDS;
            return c;
        endfunction

        function int unsigned field_size(int unsigned i);
            if (i >= NUM_TYPED)
                return 1;
            return 1 << types[2*i +: 2];
        endfunction

        function int unsigned largest();
            int unsigned m;
            m = 1;
            for (int unsigned i = 0; i < eff_fields(); i++)
                if (field_size(i) > m)
                    m = field_size(i);
            return m;
        endfunction

        function int unsigned pad_to(int unsigned off, int unsigned align);
            return (align - (off & (align - 1))) & (align - 1);
        endfunction

        function int unsigned stream_bytes();
            int unsigned off;
            off = 0;
            for (int unsigned i = 0; i < eff_fields(); i++)
                off += pad_to(off, field_size(i)) + field_size(i);
            off += pad_to(off, largest());
            return off * ((n_records == 0) ? 1 : 32'(n_records));
        endfunction

        function void absorb(logic [BYTE_W-1:0] b);
            int unsigned size;
            int unsigned cnt;
            int unsigned rc;
            logic        rec;
            logic        str;
            logic        done;
            rec = 1'b0;
            str = 1'b0;
            if (pad_left != 0) begin
                pad_left = pad_left - 1;
                offset = (offset + 1) & 8'hFF;
                return;
            end
            size = field_size(field_idx);
            fbuf[BIDX_W'(byte_idx)] = b;
            done = (byte_idx + 1) >= size;
            offset = (offset + 1) & 8'hFF;
            if (done) begin
                field_idx++;
                if (field_idx >= eff_fields()) begin
                    rec = 1'b1;
                    pad_left = pad_to(offset, largest()) & 7;
                    field_idx = 0;
                    offset = 0;
                    rc = (n_records == 0) ? 1 : 32'(n_records);
                    records = (records + 1) & 8'hFF;
                    if (records >= rc) begin
                        str = 1'b1;
                        records = 0;
                    end
                end
                else begin
                    pad_left = pad_to(offset, field_size(field_idx)) & 7;
                end
            end
            if (!swap) begin
                packed_q.push_back('{b, rec, str, 1'b1});
            end
            else if (done) begin
                cnt = byte_idx + 1;
                for (int unsigned k = cnt; k > 0; k--)
                    packed_q.push_back('{fbuf[BIDX_W'(k - 1)], rec && k == 1,
                                         str && k == 1, k == 1});
            end
            byte_idx = done ? 0 : ((byte_idx + 1) & 7);
        endfunction

        function void check_out(logic [BYTE_W-1:0] data, logic rec, logic str, logic last);
            packed_byte_t want;
            if (packed_q.size() == 0) begin
                flag($sformatf("unexpected result: byte %02h record_end %0b stream_end %0b run_last %0b",
                               data, rec, str, last));
                return;
            end
            want = packed_q.pop_front();
            if (want.data !== data || want.rec_end !== rec || want.str_end !== str ||
                want.last !== last)
                flag($sformatf({"mismatch: expected byte %02h record_end %0b stream_end %0b ",
                                "run_last %0b, got byte %02h record_end %0b stream_end %0b ",
                                "run_last %0b"}, want.data, want.rec_end, want.str_end,
                               want.last, data, rec, str, last));
        endfunction

        function void close();
            if (packed_q.size() != 0)
                flag($sformatf("%0d expected results never arrived", packed_q.size()));
        endfunction
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    logic [BYTE_W-1:0]     mem_byte = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic [BYTE_W-1:0]     out_byte;
    logic                  record_end;
    logic                  stream_end;
    logic                  run_last;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    packer_scoreboard sb;
    bit               idle_on = 1'b0;
    bit               stall_on = 1'b0;
    bit               hold_req = 1'b0;
    int unsigned      bytes_sent = 0;
    int               quiet = 0;

    aligned_struct_packer DUT (.*);

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_we)
                sb.write_reg(cfg_reg_t'(cfg_index), cfg_data);
            if (in_valid && in_ready)
                sb.absorb(mem_byte);
            if (out_valid && out_ready)
                sb.check_out(out_byte, record_end, stream_end, run_last);
            if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we)
                quiet = 0;
            else
                quiet++;
            if (quiet >= STALL_LIMIT)
            begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    // receiver: random stalls plus one long hold-off on request
    initial
    begin
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            if (hold_req)
            begin
                hold_req = 1'b0;
                out_ready <= 1'b0;
                repeat (LONG_HOLD) @(negedge clk);
            end
            else if (stall_on && $urandom_range(0, 3) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 7)) @(negedge clk);
            end
            out_ready <= 1'b1;
            repeat ($urandom_range(1, 8)) @(negedge clk);
        end
    end

    task automatic push_byte(input logic [BYTE_W-1:0] b);
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(negedge clk);
        end
        in_valid <= 1'b1;
        mem_byte <= b;
        do @(posedge clk); while (!in_ready);
        bytes_sent++;
        @(negedge clk);
    endtask

    task automatic send_bytes(input int unsigned n, input bit alternate);
        for (int unsigned i = 0; i < n; i++)
            push_byte(alternate ? (i[0] ? 8'hFF : 8'h00) : 8'($urandom_range(0, 255)));
        in_valid <= 1'b0;
    endtask

    task automatic drain_results();
        while (sb.pending() != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] d);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= d;
        @(negedge clk);
    endtask

    task automatic configure(input int unsigned cnt, input logic [TYPES_W-1:0] types,
                             input bit be, input int unsigned recs);
        drain_results();
        write_reg(REG_FIELD_COUNT, cnt);
        write_reg(REG_FIELD_TYPES, types);
        write_reg(REG_BIG_ENDIAN, CFG_DATA_W'(be));
        write_reg(REG_RECORD_COUNT, recs);
        cfg_we <= 1'b0;
    endtask

    task automatic realign();
        configure(1, '0, 1'($urandom_range(0, 1)), 1);
        while (!sb.at_stream_start())
            send_bytes(1, 1'b0);
    endtask

    initial
    begin
        int unsigned        cnt;
        int unsigned        recs;
        int unsigned        n;
        int unsigned        phase;
        int unsigned        goal;
        logic [TYPES_W-1:0] types;
        bit                 be;
        sb = new();
        repeat (10) @(negedge clk);
        rst_n = 1'b1;

        // reset layout, then byte + long in big-endian, then zero counts
        send_bytes(2, 1'b1);
        configure(2, 32'h0000_000C, 1'b1, 1);
        send_bytes(16, 1'b1);
        configure(0, 32'h0000_0001, 1'b0, 0);
        send_bytes(2, 1'b1);

        goal = bytes_sent + RANDOM_ITEMS;
        phase = 0;
        while (bytes_sent < goal || phase <= 2)
        begin
            idle_on = ($urandom_range(0, 3) != 0);
            stall_on = ($urandom_range(0, 3) != 0);
            types = $urandom();
            cnt = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 31) : $urandom_range(1, 4);
            recs = (cnt > 4) ? 1 : $urandom_range(0, 3);
            be = $urandom_range(0, 1);
            if (phase == 2)
            begin
                cnt = 4;
                types = 32'h0000_00FF;
                be = 1'b1;
                recs = 2;
            end
            configure(cnt, types, be, recs);
            n = sb.stream_bytes();
            if (phase == 2)
                hold_req = 1'b1;
            if (phase != 2 && $urandom_range(0, 4) == 0)
            begin
                // stop at a random point in the stream, change layout and byte order, then resync
                send_bytes($urandom_range(1, n), 1'b0);
                configure($urandom_range(1, 4), $urandom(), !be, $urandom_range(1, 3));
                send_bytes($urandom_range(1, 12), 1'b0);
                realign();
            end
            else
            begin
                send_bytes(n, 1'b0);
            end
            phase++;
        end

        idle_on = 1'b0;
        stall_on = 1'b0;
        configure(31, 32'h0000_0000, 1'b0, 1);
        send_bytes(sb.stream_bytes(), 1'b0);
        configure(16, 32'hC000_0000, 1'b1, 1);
        send_bytes(sb.stream_bytes(), 1'b0);
        configure(1, 32'h0000_0000, 1'b1, 40);
        send_bytes(sb.stream_bytes(), 1'b0);

        while (sb.pending() != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);
        sb.close();
        if (sb.errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

FILE: sim.f
hdl/asp_pkg.sv
hdl/asp_cfg.sv
hdl/asp_ctrl.sv
hdl/asp_emit.sv
hdl/aligned_struct_packer.sv
test/aligned_struct_packer_tb.sv
